/* rtl/ddw_pkg.sv */
// ----------------------------------------------------------------------------
// ddw_pkg
// Types, constants and calendar functions of the date difference unit.
// ----------------------------------------------------------------------------
package ddw_pkg;

	localparam logic [11:0] YEAR_MIN = 12'd1901;
	localparam logic [11:0] YEAR_MAX = 12'd2099;

	localparam int unsigned DAY_W = 17;

	typedef enum logic [1:0] {
		ORDER_EQUAL   = 2'd0,
		ORDER_EARLIER = 2'd1,
		ORDER_LATER   = 2'd2
	} order_t;

	typedef enum logic [1:0] {
		REG_REF_YEAR    = 2'd0,
		REG_REF_MONTH   = 2'd1,
		REG_REF_DAY     = 2'd2,
		REG_REF_WEEKDAY = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
	} date_t;

	typedef struct packed {
		date_t second;
		date_t first;
	} item_t;

	typedef struct packed {
		logic        bad_date;
		logic [2:0]  second_weekday;
		logic [DAY_W-1:0] day_count;
		logic [1:0]  order;
	} result_t;

	function automatic logic [4:0] month_len(input logic [11:0] year, input logic [3:0] month);
		logic [4:0] n;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
			4'd2:    n = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] month);
		logic [8:0] s;
		case (month)
			4'd2:    s = 9'd31;
			4'd3:    s = 9'd59;
			4'd4:    s = 9'd90;
			4'd5:    s = 9'd120;
			4'd6:    s = 9'd151;
			4'd7:    s = 9'd181;
			4'd8:    s = 9'd212;
			4'd9:    s = 9'd243;
			4'd10:   s = 9'd273;
			4'd11:   s = 9'd304;
			4'd12:   s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	function automatic logic [2:0] month_start_mod7(input logic [3:0] month);
		logic [2:0] s;
		case (month)
			4'd2, 4'd3, 4'd11: s = 3'd3;
			4'd4, 4'd7:        s = 3'd6;
			4'd5:              s = 3'd1;
			4'd6:              s = 3'd4;
			4'd8:              s = 3'd2;
			4'd9, 4'd12:       s = 3'd5;
			default:           s = 3'd0;
		endcase
		return s;
	endfunction

	// Residue modulo 7 by summing octal digits, since eight is one modulo seven.
	function automatic logic [2:0] mod7(input logic [8:0] x);
		logic [4:0] s;
		logic [3:0] t;
		s = 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
		t = 4'(s[4:3]) + 4'(s[2:0]);
		if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		return t[2:0];
	endfunction

	function automatic logic date_ok(input date_t d);
		logic ok;
		ok = (d.year >= YEAR_MIN) && (d.year <= YEAR_MAX) &&
			(d.day != 5'd0) && (d.day <= month_len(d.year, d.month));
		return ok;
	endfunction

	// Days since 1901-01-01 for a valid date.
	function automatic logic [DAY_W-1:0] day_number(input date_t d);
		logic [7:0] y;
		logic [DAY_W-1:0] n;
		y = 8'(d.year - YEAR_MIN);
		n = DAY_W'(y) * DAY_W'(365) + DAY_W'(y[7:2]) + DAY_W'(month_start(d.month)) +
			DAY_W'(d.day) - DAY_W'(1);
		if ((d.month > 4'd2) && (d.year[1:0] == 2'b00)) begin
			n = n + DAY_W'(1);
		end
		return n;
	endfunction

	// Day number modulo 7, using 365 being one modulo seven.
	function automatic logic [2:0] day_number_mod7(input date_t d);
		logic [7:0] y;
		logic [8:0] s;
		y = 8'(d.year - YEAR_MIN);
		s = 9'(y) + 9'(y[7:2]) + 9'(month_start_mod7(d.month)) + 9'(d.day) - 9'd1;
		if ((d.month > 4'd2) && (d.year[1:0] == 2'b00)) begin
			s = s + 9'd1;
		end
		return mod7(s);
	endfunction

endpackage

/* rtl/date_difference_and_weekday.sv */
// ----------------------------------------------------------------------------
// date_difference_and_weekday
// Days between two dates, their order and the weekday of the second date.
// ----------------------------------------------------------------------------
// The block takes one word of two dates in every cycle unless the output
// stalls, and returns one result word per word, held first in the input
// register, then after the calendar arithmetic in the result register. Leap
// years are every fourth year, so dates must lie within 1901..2099. The weekday
// is counted from the reference date in the configuration registers, which are
// saturated into range before use; write them only while no word is in flight.
module date_difference_and_weekday (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// first_year, first_month, first_day, second_year, second_month, second_day
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// order, day_count, second_weekday, bad_date
	output logic [23:0] m_axis_tdata
);

	logic [11:0] ref_year_q;
	logic [3:0]  ref_month_q;
	logic [4:0]  ref_day_q;
	logic [2:0]  ref_weekday_q;

	logic             valid_s1;
	ddw_pkg::item_t   item_s1;
	logic             valid_s2;
	ddw_pkg::result_t result_s2;

	logic             advance_s2;
	ddw_pkg::date_t   ref_date;
	logic [4:0]       ref_len;
	ddw_pkg::result_t result;
	logic [ddw_pkg::DAY_W-1:0] n1;
	logic [ddw_pkg::DAY_W-1:0] n2;
	logic [2:0]       wd_ref;
	logic [4:0]       wd_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_year_q    <= 12'd2015;
			ref_month_q   <= 4'd6;
			ref_day_q     <= 5'd8;
			ref_weekday_q <= 3'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ddw_pkg::REG_REF_YEAR:    ref_year_q    <= cfg_data;
				ddw_pkg::REG_REF_MONTH:   ref_month_q   <= cfg_data[3:0];
				ddw_pkg::REG_REF_DAY:     ref_day_q     <= cfg_data[4:0];
				ddw_pkg::REG_REF_WEEKDAY: ref_weekday_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign advance_s2    = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= ddw_pkg::item_t'(s_axis_tdata[41:0]);
		end
		if (advance_s2 && valid_s1) begin
			result_s2 <= result;
		end
	end

	always_comb begin
		ref_date.year = ref_year_q;
		if (ref_year_q < ddw_pkg::YEAR_MIN) begin
			ref_date.year = ddw_pkg::YEAR_MIN;
		end else if (ref_year_q > ddw_pkg::YEAR_MAX) begin
			ref_date.year = ddw_pkg::YEAR_MAX;
		end
		ref_date.month = ref_month_q;
		if (ref_month_q == 4'd0) begin
			ref_date.month = 4'd1;
		end else if (ref_month_q > 4'd12) begin
			ref_date.month = 4'd12;
		end
		ref_len = ddw_pkg::month_len(ref_date.year, ref_date.month);
		ref_date.day = ref_day_q;
		if (ref_day_q == 5'd0) begin
			ref_date.day = 5'd1;
		end else if (ref_day_q > ref_len) begin
			ref_date.day = ref_len;
		end
	end

	always_comb begin
		n1     = ddw_pkg::day_number(item_s1.first);
		n2     = ddw_pkg::day_number(item_s1.second);
		wd_ref = (ref_weekday_q == 3'd7) ? 3'd0 : ref_weekday_q;
		wd_sum = 5'(wd_ref) + 5'(ddw_pkg::day_number_mod7(item_s1.second)) + 5'd7 -
			5'(ddw_pkg::day_number_mod7(ref_date));

		result.bad_date       = 1'b0;
		result.second_weekday = ddw_pkg::mod7(9'(wd_sum));
		if (n1 == n2) begin
			result.order     = ddw_pkg::ORDER_EQUAL;
			result.day_count = '0;
		end else if (n1 < n2) begin
			result.order     = ddw_pkg::ORDER_EARLIER;
			result.day_count = n2 - n1;
		end else begin
			result.order     = ddw_pkg::ORDER_LATER;
			result.day_count = n1 - n2;
		end
		if (!ddw_pkg::date_ok(item_s1.first) || !ddw_pkg::date_ok(item_s1.second)) begin
			result = '0;
			result.bad_date = 1'b1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, result_s2};

endmodule
